/* design/cle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// Shared opcodes, status codes, sequencer states and the result record of the
// circular list engine.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int POS_W  = 8;
  localparam int STAT_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_PREPEND = 3'd1,
    OP_INSERT  = 3'd2,
    OP_DELETE  = 3'd3,
    OP_DUMP    = 3'd4
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FEW      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_LINK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_t                  status;
    logic                     last;
  } res_t;

endpackage

/* design/cle_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_if
// Valid/ready channels of the circular list engine: one for requests and one
// for results.
// ----------------------------------------------------------------------------
interface cle_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] value;
  logic [7:0]         position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

interface cle_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] data;
  logic [2:0]         status;
  logic               last_of_run;

  modport source (output valid, output data, output status, output last_of_run, input ready);
  modport sink   (input valid, input data, input status, input last_of_run, output ready);
endinterface

/* design/cle_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module cle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/cle_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_seq
// List sequencer: keeps tail, count and the in-use map, walks the node pool
// one node per cycle unless dump output is held, and issues node reads/writes.
// ----------------------------------------------------------------------------
module cle_seq #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  cle_in_if.sink                        in_ch,
  output logic [$clog2(LIST_DEPTH)-1:0] rd_addr,
  input  logic [31:0]                   rd_value,
  input  logic [$clog2(LIST_DEPTH)-1:0] rd_next,
  output logic                          val_we,
  output logic [$clog2(LIST_DEPTH)-1:0] val_waddr,
  output logic [31:0]                   val_wdata,
  output logic                          nxt_we,
  output logic [$clog2(LIST_DEPTH)-1:0] nxt_waddr,
  output logic [$clog2(LIST_DEPTH)-1:0] nxt_wdata,
  output logic                          res_valid,
  output cle_pkg::res_t                 res,
  input  logic                          res_take
);
  import cle_pkg::*;

  localparam int IW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int SW = (CW > POS_W) ? CW : POS_W;

  state_t               state_r, state_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [DATA_W-1:0]    val_r, val_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [IW-1:0]        q_r, q_nxt;
  logic [IW-1:0]        prev_r, prev_nxt;
  logic [IW-1:0]        head_r, head_nxt;
  logic [IW-1:0]        n_r, n_nxt;
  logic [SW-1:0]        step_r, step_nxt;
  status_t              stat_r, stat_nxt;
  logic [IW-1:0]        tail_r, tail_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [LIST_DEPTH-1:0] in_use_r, in_use_nxt;

  logic          full;
  logic          empty;
  logic [IW-1:0] free_idx;
  logic [SW-1:0] step_inc;
  logic          at_end;
  logic          walk_more;
  logic          match;
  logic          wrapped;

  assign full      = (count_r == CW'(LIST_DEPTH));
  assign empty     = (count_r == '0);
  assign step_inc  = step_r + SW'(1);
  assign at_end    = (step_inc == SW'(count_r));
  assign walk_more = (step_r < SW'(pos_r));
  assign match     = (rd_value == val_r);
  assign wrapped   = (rd_next == head_r);

  always_comb begin
    free_idx = '0;
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tail_r   <= '0;
      count_r  <= '0;
      in_use_r <= '0;
    end else begin
      state_r  <= state_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      in_use_r <= in_use_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    pos_r  <= pos_nxt;
    q_r    <= q_nxt;
    prev_r <= prev_nxt;
    head_r <= head_nxt;
    n_r    <= n_nxt;
    step_r <= step_nxt;
    stat_r <= stat_nxt;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.opcode) inside
            OP_APPEND, OP_PREPEND:      state_nxt = full ? S_RESP : S_HEAD;
            OP_INSERT, OP_DELETE, OP_DUMP: state_nxt = empty ? S_RESP : S_HEAD;
            default:                    state_nxt = S_IDLE;
          endcase
        end
      end
      S_HEAD: begin
        case (op_r) inside
          OP_APPEND, OP_PREPEND: state_nxt = empty ? S_RESP : S_LINK;
          default:               state_nxt = S_WALK;
        endcase
      end
      S_WALK: begin
        case (op_r)
          OP_INSERT: begin
            if (walk_more) begin
              state_nxt = wrapped ? S_RESP : S_WALK;
            end else begin
              state_nxt = full ? S_RESP : S_LINK;
            end
          end
          OP_DELETE: state_nxt = (match || at_end) ? S_RESP : S_WALK;
          OP_DUMP:   state_nxt = (res_take && at_end) ? S_IDLE : S_WALK;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_LINK: state_nxt = S_RESP;
      S_RESP: state_nxt = res_take ? S_IDLE : S_RESP;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    op_nxt     = op_r;
    val_nxt    = val_r;
    pos_nxt    = pos_r;
    q_nxt      = q_r;
    prev_nxt   = prev_r;
    head_nxt   = head_r;
    n_nxt      = n_r;
    step_nxt   = step_r;
    stat_nxt   = stat_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    in_use_nxt = in_use_r;
    in_ch.ready = 1'b0;
    rd_addr    = q_r;
    val_we     = 1'b0;
    val_waddr  = free_idx;
    val_wdata  = val_r;
    nxt_we     = 1'b0;
    nxt_waddr  = free_idx;
    nxt_wdata  = rd_next;
    res_valid  = 1'b0;
    res        = '{data: '0, status: stat_r, last: 1'b1};

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        rd_addr     = tail_r;
        if (in_ch.valid) begin
          op_nxt  = in_ch.opcode;
          val_nxt = in_ch.value;
          pos_nxt = in_ch.position;
          case (in_ch.opcode) inside
            OP_APPEND, OP_PREPEND: stat_nxt = ST_FULL;
            default:               stat_nxt = ST_EMPTY;
          endcase
        end
      end
      S_HEAD: begin
        head_nxt = rd_next;
        q_nxt    = rd_next;
        prev_nxt = tail_r;
        n_nxt    = free_idx;
        rd_addr  = rd_next;
        step_nxt = (op_r == OP_INSERT) ? SW'(1) : '0;
        if (op_r == OP_APPEND || op_r == OP_PREPEND) begin
          val_we   = 1'b1;
          nxt_we   = 1'b1;
          stat_nxt = ST_OK;
          if (empty) begin
            nxt_wdata            = free_idx;
            tail_nxt             = free_idx;
            in_use_nxt[free_idx] = 1'b1;
            count_nxt            = count_r + CW'(1);
          end
        end
      end
      S_WALK: begin
        case (op_r)
          OP_INSERT: begin
            if (walk_more) begin
              if (wrapped) begin
                stat_nxt = ST_FEW;
              end else begin
                q_nxt    = rd_next;
                step_nxt = step_inc;
                rd_addr  = rd_next;
              end
            end else if (full) begin
              stat_nxt = ST_FULL;
            end else begin
              val_we   = 1'b1;
              nxt_we   = 1'b1;
              n_nxt    = free_idx;
              stat_nxt = ST_OK;
            end
          end
          OP_DELETE: begin
            if (match) begin
              stat_nxt = ST_OK;
              if (count_r == CW'(1)) begin
                tail_nxt = '0;
              end else begin
                nxt_we    = 1'b1;
                nxt_waddr = prev_r;
                if (q_r == tail_r) begin
                  tail_nxt = prev_r;
                end
              end
              in_use_nxt[q_r] = 1'b0;
              count_nxt       = count_r - CW'(1);
            end else if (at_end) begin
              stat_nxt = ST_NOTFOUND;
            end else begin
              prev_nxt = q_r;
              q_nxt    = rd_next;
              step_nxt = step_inc;
              rd_addr  = rd_next;
            end
          end
          OP_DUMP: begin
            res_valid = 1'b1;
            res       = '{data: rd_value, status: ST_OK, last: at_end};
            if (res_take && !at_end) begin
              q_nxt    = rd_next;
              step_nxt = step_inc;
              rd_addr  = rd_next;
            end
          end
          default: begin
          end
        endcase
      end
      S_LINK: begin
        nxt_we          = 1'b1;
        nxt_waddr       = (op_r == OP_INSERT) ? q_r : tail_r;
        nxt_wdata       = n_r;
        in_use_nxt[n_r] = 1'b1;
        count_nxt       = count_r + CW'(1);
        if (op_r == OP_APPEND || (op_r == OP_INSERT && q_r == tail_r)) begin
          tail_nxt = n_r;
        end
      end
      S_RESP: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(in_use_r) == int'(count_r))
    else $error("element count disagrees with the in-use map");

  a_tail_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> in_use_r[tail_r])
    else $error("tail node is not marked in use");

  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (tail_r == '0))
    else $error("empty list with a nonzero tail");

  a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && op_r == OP_DUMP && res_take && at_end) |=> (state_r == S_IDLE))
    else $error("dump did not finish after its last transaction");

endmodule

/* design/circular_list_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_list_engine
// Bounded circular singly linked list of signed 32-bit values in a node pool.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch (opcode, value, position); results leave on out_ch
// (data, status, last_of_run). Both are valid/ready channels, and a
// transaction completes on a clock edge with valid and ready high.
// One request is handled at a time; in_ch.ready is high only while the
// sequencer is idle. Every request except an unused opcode gives at least one
// result, and the last result of a request has last_of_run set.
// A request that is refused at once (full pool for append and prepend, or an
// empty list for insert-after, delete and dump) goes from idle straight to the
// response state. Append and prepend pass through the head, link and response
// states, and skip the link state when the list is empty. Insert-after and
// delete walk the list one node per cycle through the registered read port
// of the node memory. A dump passes through the head state and then delivers
// one value per cycle from the walk state while the receiver takes them. The
// block is ready for the next request in the cycle after the final result
// enters the output register, even while that result still waits.
// A stalled receiver holds the output register and, during a dump, pauses the
// walk. Reset empties the list; node memory needs no clearing because data
// read from nodes outside the list is never used.
// ----------------------------------------------------------------------------
module circular_list_engine #(
  parameter int LIST_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  cle_in_if.sink   in_ch,
  cle_out_if.source out_ch
);
  import cle_pkg::*;

  localparam int IW = $clog2(LIST_DEPTH);

  logic [IW-1:0] rd_addr;
  logic [31:0]   rd_value;
  logic [IW-1:0] rd_next;
  logic          val_we;
  logic [IW-1:0] val_waddr;
  logic [31:0]   val_wdata;
  logic          nxt_we;
  logic [IW-1:0] nxt_waddr;
  logic [IW-1:0] nxt_wdata;
  logic          res_valid;
  res_t          res;
  logic          res_take;

  logic          out_valid_r;
  res_t          out_res_r;

  cle_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (rd_addr),
    .rdata (rd_value)
  );

  cle_ram #(.WIDTH(IW), .DEPTH(LIST_DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (rd_addr),
    .rdata (rd_next)
  );

  cle_seq #(.LIST_DEPTH(LIST_DEPTH)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .rd_addr   (rd_addr),
    .rd_value  (rd_value),
    .rd_next   (rd_next),
    .val_we    (val_we),
    .val_waddr (val_waddr),
    .val_wdata (val_wdata),
    .nxt_we    (nxt_we),
    .nxt_waddr (nxt_waddr),
    .nxt_wdata (nxt_wdata),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  assign res_take = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.data        = out_res_r.data;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.last_of_run = out_res_r.last;

endmodule

/* bench/cle_list_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_list_monitor
// Watches both channels of the circular list engine, keeps its own copy of
// the node pool and list pointers, predicts the results of every accepted
// request and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module cle_list_monitor #(
  parameter int LIST_DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  cle_in_if    req_bus,
  cle_out_if   res_bus,
  output int   fail_count,
  output int   pending_results
);
  import cle_pkg::*;

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  logic signed [DATA_W-1:0] pool_value [LIST_DEPTH];
  logic [IDX_W-1:0]         pool_next  [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]    pool_used;
  logic [IDX_W-1:0]         tail_at;
  logic [CNT_W-1:0]         elem_count;
  res_t                     expected_results [$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void queue_result(input logic signed [DATA_W-1:0] d,
                                       input status_t s, input logic l);
    res_t r;
    r.data   = d;
    r.status = s;
    r.last   = l;
    expected_results.push_back(r);
  endfunction

  function automatic logic [IDX_W-1:0] take_free_node(input logic signed [DATA_W-1:0] v);
    int i;
    for (i = 0; i < LIST_DEPTH; i++) begin
      if (!pool_used[i]) begin
        pool_used[i]  = 1'b1;
        pool_value[i] = v;
        elem_count    = elem_count + 1'b1;
        return IDX_W'(i);
      end
    end
    return '0;
  endfunction

  function automatic void link_after(input logic [IDX_W-1:0] at, input logic [IDX_W-1:0] n);
    pool_next[n]  = pool_next[at];
    pool_next[at] = n;
  endfunction

  function automatic void place_at_tail(input logic signed [DATA_W-1:0] v);
    logic             was_empty;
    logic [IDX_W-1:0] n;
    was_empty = (elem_count == 0);
    n = take_free_node(v);
    if (was_empty) begin
      pool_next[n] = n;
    end else begin
      link_after(tail_at, n);
    end
    tail_at = n;
  endfunction

  task automatic predict_list_op(input logic [OP_W-1:0] op,
                                 input logic signed [DATA_W-1:0] val,
                                 input logic [POS_W-1:0] pos);
    logic [IDX_W-1:0] head, cur, prv, fresh;
    logic             full, hit;
    int               i;
    full = (elem_count >= LIST_DEPTH);
    case (opcode_t'(op))
      OP_APPEND: begin
        if (full) begin
          queue_result('0, ST_FULL, 1'b1);
        end else begin
          place_at_tail(val);
          queue_result('0, ST_OK, 1'b1);
        end
      end
      OP_PREPEND: begin
        if (full) begin
          queue_result('0, ST_FULL, 1'b1);
        end else begin
          if (elem_count == 0) begin
            place_at_tail(val);
          end else begin
            fresh = take_free_node(val);
            link_after(tail_at, fresh);
          end
          queue_result('0, ST_OK, 1'b1);
        end
      end
      OP_INSERT: begin
        if (elem_count == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
        end else begin
          head = pool_next[tail_at];
          cur  = head;
          hit  = 1'b0;
          for (i = 1; i < pos && !hit; i++) begin
            cur = pool_next[cur];
            if (cur == head) hit = 1'b1;
          end
          if (hit) begin
            queue_result('0, ST_FEW, 1'b1);
          end else if (full) begin
            queue_result('0, ST_FULL, 1'b1);
          end else begin
            fresh = take_free_node(val);
            link_after(cur, fresh);
            if (cur == tail_at) tail_at = fresh;
            queue_result('0, ST_OK, 1'b1);
          end
        end
      end
      OP_DELETE: begin
        if (elem_count == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
        end else begin
          prv = tail_at;
          cur = pool_next[tail_at];
          hit = 1'b0;
          for (i = 0; i < elem_count && !hit; i++) begin
            if (pool_value[cur] == val) begin
              if (elem_count == 1) begin
                tail_at = '0;
              end else begin
                pool_next[prv] = pool_next[cur];
                if (cur == tail_at) tail_at = prv;
              end
              pool_used[cur] = 1'b0;
              elem_count     = elem_count - 1'b1;
              hit            = 1'b1;
            end else begin
              prv = cur;
              cur = pool_next[cur];
            end
          end
          queue_result('0, hit ? ST_OK : ST_NOTFOUND, 1'b1);
        end
      end
      OP_DUMP: begin
        if (elem_count == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
        end else begin
          cur = pool_next[tail_at];
          for (i = 0; i < elem_count; i++) begin
            queue_result(pool_value[cur], ST_OK, (i + 1 == elem_count));
            cur = pool_next[cur];
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : watch_channels
    res_t want;
    if (!rst_n) begin
      pool_used  = '0;
      tail_at    = '0;
      elem_count = '0;
      expected_results.delete();
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        predict_list_op(req_bus.opcode, req_bus.value, req_bus.position);
      end
      if (res_bus.valid && res_bus.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result data=%0d status=%0d last=%0b",
                                    res_bus.data, res_bus.status, res_bus.last_of_run));
        end else begin
          want = expected_results.pop_front();
          if (res_bus.data !== want.data) begin
            report_mismatch($sformatf("data %0d, expected %0d", res_bus.data, want.data));
          end
          if (res_bus.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", res_bus.status,
                                      want.status));
          end
          if (res_bus.last_of_run !== want.last) begin
            report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                      res_bus.last_of_run, want.last));
          end
        end
      end
    end
    pending_results <= expected_results.size();
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the circular list engine bench. Runs a directed sequence over the
// empty, single and wrap-around cases, then random phases that grow,
// shrink and mix the list, with random idling on both channels and one long
// receiver stall. The list monitor does all checking; this module drives the
// requests, paces the results and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import cle_pkg::*;

  localparam int LIST_DEPTH   = 16;
  localparam int RANDOM_ITEMS = 140;
  localparam int PHASE_ITEMS  = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 300;

  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  int   fail_count;
  int   pending_results;
  bit   hold_request = 1'b0;
  bit   no_gaps = 1'b0;
  int   random_sent = 0;

  logic signed [DATA_W-1:0] inserted_vals [$];

  cle_in_if  req_bus ();
  cle_out_if res_bus ();

  circular_list_engine #(
    .LIST_DEPTH(LIST_DEPTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_bus),
    .out_ch(res_bus)
  );

  cle_list_monitor #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_list_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_bus        (req_bus),
    .res_bus        (res_bus),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] v,
                           input logic [POS_W-1:0] p);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.opcode   <= op;
    req_bus.value    <= v;
    req_bus.position <= p;
    do @(posedge clk); while (!req_bus.ready);
    if (op == OP_APPEND || op == OP_PREPEND || op == OP_INSERT) begin
      inserted_vals.push_back(v);
      if (inserted_vals.size() > 32) void'(inserted_vals.pop_front());
    end
  endtask

  function automatic logic [POS_W-1:0] pick_pos(input int hi);
    return POS_W'($urandom_range(0, hi));
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 7);
    if (r < 65) return 32'sh7fff_ffff;
    if (r < 70) return 32'sh8000_0000;
    return $urandom;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_victim();
    if (inserted_vals.size() > 0 && $urandom_range(0, 4) != 0) begin
      return inserted_vals[$urandom_range(0, inserted_vals.size() - 1)];
    end
    return pick_value();
  endfunction

  initial begin
    int               phase_kind;
    int               k;
    int               r;
    logic [OP_W-1:0]  op_pick;
    rst_n            <= 1'b0;
    req_bus.valid    <= 1'b0;
    req_bus.opcode   <= OP_APPEND;
    req_bus.value    <= '0;
    req_bus.position <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_item(OP_DUMP, 0, 0);
    send_item(OP_DELETE, 5, 0);
    send_item(OP_INSERT, 9, 3);
    send_item(OP_PREPEND, 32'sh7fff_ffff, 0);
    send_item(OP_DELETE, 32'sh7fff_ffff, 0);
    send_item(OP_APPEND, 32'sh8000_0000, 8'hff);
    send_item(OP_PREPEND, -1, 0);
    send_item(OP_APPEND, 0, 0);
    send_item(OP_INSERT, 11, 0);
    send_item(OP_INSERT, 12, 1);
    send_item(OP_INSERT, 13, 5);
    send_item(OP_INSERT, 14, 7);
    send_item(OP_INSERT, 15, 8'hff);
    send_item(OP_DELETE, 99, 0);
    send_item(OP_DELETE, 13, 0);
    send_item(OP_DELETE, -1, 0);
    send_item(OP_DUMP, 0, 0);
    send_item(OP_SPARE_A, 1, 1);
    send_item(OP_SPARE_B, 2, 2);
    send_item(OP_SPARE_C, 3, 3);
    send_item(OP_DELETE, 12, 0);
    send_item(OP_DUMP, 0, 0);

    while (random_sent < RANDOM_ITEMS) begin
      phase_kind = $urandom_range(0, 2);
      no_gaps    = ($urandom_range(0, 3) == 0);
      if (random_sent == 0) begin
        // Keep offering requests while the receiver is held off.
        phase_kind   = 0;
        no_gaps      = 1'b1;
        hold_request = 1'b1;
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        case (phase_kind)
          0: begin
            if (k == PHASE_ITEMS - 1) send_item(OP_DUMP, pick_value(), pick_pos(255));
            else if (r < 45) send_item(OP_APPEND, pick_value(), pick_pos(255));
            else if (r < 75) send_item(OP_PREPEND, pick_value(), pick_pos(255));
            else if (r < 90) send_item(OP_INSERT, pick_value(), pick_pos(4));
            else if (r < 95) send_item(OP_INSERT, pick_value(), 8'hff);
            else send_item(OP_DUMP, 0, 0);
            random_sent++;
          end
          1: begin
            if (r < 70) send_item(OP_DELETE, pick_victim(), pick_pos(255));
            else if (r < 80) send_item(OP_DELETE, pick_value(), 0);
            else if (r < 90) send_item(OP_INSERT, pick_value(), pick_pos(6));
            else send_item(OP_DUMP, 0, 0);
            random_sent++;
          end
          default: begin
            if (r < 4) begin
              op_pick = OP_SPARE_A + OP_W'($urandom_range(0, 2));
              send_item(op_pick, $urandom, pick_pos(255));
            end else begin
              op_pick = OP_W'($urandom_range(0, 4));
              if (op_pick == OP_DELETE) begin
                send_item(op_pick, pick_victim(), pick_pos(255));
              end else if (r < 50) begin
                send_item(op_pick, $urandom, pick_pos(255));
              end else begin
                send_item(op_pick, pick_value(), pick_pos(8));
              end
              random_sent++;
            end
          end
        endcase
      end
    end
    req_bus.valid <= 1'b0;

    do @(posedge clk); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int stall;
    res_bus.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        res_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = no_gaps ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!res_bus.valid);
    end
  end

endmodule

/* circular_list_engine.f */
design/cle_pkg.sv
design/cle_if.sv
design/cle_ram.sv
design/cle_seq.sv
design/circular_list_engine.sv
bench/cle_list_monitor.sv
bench/tb.sv
